/* hw/rtl/moving_sphere_collision_macros.svh */
// Assertion shorthands shared by the FIFO and back-end RTL files.
// Every use needs clk and rst_n in scope.
`ifndef MOVING_SPHERE_COLLISION_MACROS_SVH
`define MOVING_SPHERE_COLLISION_MACROS_SVH

// Same-cycle implication.
`define MSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define MSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/msc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

    localparam int CW          = 20;            // coordinate width
    localparam int DW          = CW + 1;        // difference of two coordinates
    localparam int VW          = 3 * CW;        // packed vector
    localparam int RW          = 20;            // radius
    localparam int RSW         = RW + 1;        // radius sum
    localparam int TW          = 32;            // time, Q16.16
    localparam int TFRAC       = 16;
    localparam int AW          = 2 * DW;        // a = v.v, magnitudes of h and c
    localparam int HW          = AW + 1;        // h = p.v, signed
    localparam int QW          = AW + 2;        // c, signed
    localparam int HALF        = DW;            // split point of the wide products
    localparam int XW          = 2 * HW;        // discriminant
    localparam int SW          = XW / 2;        // its root
    localparam int NW          = SW + 2;        // root numerators, signed
    localparam int PRW         = CW + TW + 1;   // velocity times time
    localparam int EW          = CW + TW - TFRAC + 2;
    localparam int MW          = DW + RW;       // |w| * radius
    localparam int QB          = DW;            // contact quotient bits
    localparam int CNTW        = 6;
    localparam int RND         = 1 << (TFRAC - 1);
    localparam int FRONT_DEPTH = 6;
    localparam int FIFO_DEPTH  = 4;
    localparam int FPW         = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [VW-1:0] center_a;
        logic [RW-1:0] radius_a;
        logic [VW-1:0] velocity_a;
        logic [VW-1:0] center_b;
        logic [RW-1:0] radius_b;
        logic [VW-1:0] velocity_b;
    } msc_in_t;

    typedef struct packed {
        logic          hit;
        logic [VW-1:0] end_center_a;
        logic [VW-1:0] end_center_b;
        logic [VW-1:0] contact_point;
        logic [TW-1:0] hit_time;
    } msc_out_t;

    // Classified pair handed from the front end to the back end.
    typedef struct packed {
        logic                 go;
        logic [XW-1:0]        disc;
        logic signed [HW-1:0] h;
        logic [AW-1:0]        a;
        logic [VW-1:0]        ca;
        logic [VW-1:0]        va;
        logic [VW-1:0]        cb;
        logic [VW-1:0]        vb;
        logic [RW-1:0]        rb;
    } msc_job_t;

    function automatic logic signed [CW-1:0] coord(input logic [VW-1:0] vec, input int i);
        return vec[i*CW +: CW];
    endfunction

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [EW-1:0] x);
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] lo;
        hi = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = ~hi;
        if (x > hi)
        begin
            return hi[CW-1:0];
        end
        else if (x < lo)
        begin
            return lo[CW-1:0];
        end
        return x[CW-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/msc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module msc_front import msc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     valid,
    output logic     stall,
    input  msc_in_t  item,
    output logic     push,
    output msc_job_t job,
    input  logic     full
);

    typedef struct packed {
        logic [VW-1:0] ca;
        logic [VW-1:0] va;
        logic [VW-1:0] cb;
        logic [VW-1:0] vb;
        logic [RW-1:0] rb;
    } side_t;

    logic [FRONT_DEPTH-1:0] vld_reg;
    side_t                  side_reg [FRONT_DEPTH];

    logic signed [DW-1:0]  p1_reg [3];
    logic signed [DW-1:0]  v1_reg [3];
    logic [RSW-1:0]        rs1_reg;
    logic [AW-1:0]         vv2_reg [3];
    logic signed [AW-1:0]  pv2_reg [3];
    logic [AW-1:0]         pp2_reg [3];
    logic [AW-1:0]         rs2_reg;
    logic [AW-1:0]         a3_reg;
    logic signed [HW-1:0]  h3_reg;
    logic signed [QW-1:0]  c3_reg;
    logic [AW-1:0]         hmag4_reg;
    logic [AW-1:0]         cmag4_reg;
    logic [AW-1:0]         a4_reg;
    logic [AW-1:0]         a5_reg;
    logic [AW-1:0]         a6_reg;
    logic signed [HW-1:0]  h4_reg;
    logic signed [HW-1:0]  h5_reg;
    logic signed [HW-1:0]  h6_reg;
    logic [2:0]            cneg_reg;    // stages 4..6
    logic [2:0]            azero_reg;
    logic [AW-1:0]         hh11_reg;
    logic [AW-1:0]         hh10_reg;
    logic [AW-1:0]         hh00_reg;
    logic [AW-1:0]         ac11_reg;
    logic [AW-1:0]         ac10_reg;
    logic [AW-1:0]         ac01_reg;
    logic [AW-1:0]         ac00_reg;
    logic [XW-1:0]         h2_reg;
    logic [XW-1:0]         ac_reg;

    logic                  en;
    logic [XW:0]           diff;
    logic [XW-1:0]         sum;

    assign en    = !vld_reg[FRONT_DEPTH-1] || !full;
    assign stall = !en;
    assign push  = vld_reg[FRONT_DEPTH-1] && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FRONT_DEPTH-2:0], valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{ca: item.center_a, va: item.velocity_a,
                             cb: item.center_b, vb: item.velocity_b, rb: item.radius_b};
            for (int k = 1; k < FRONT_DEPTH; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            // stage 1: relative position and velocity
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= DW'(coord(item.center_b, i)) - DW'(coord(item.center_a, i));
                v1_reg[i] <= DW'(coord(item.velocity_b, i)) - DW'(coord(item.velocity_a, i));
            end
            rs1_reg <= RSW'(item.radius_a) + RSW'(item.radius_b);

            // stage 2: component products
            for (int i = 0; i < 3; i++)
            begin
                vv2_reg[i] <= v1_reg[i] * v1_reg[i];
                pv2_reg[i] <= p1_reg[i] * v1_reg[i];
                pp2_reg[i] <= p1_reg[i] * p1_reg[i];
            end
            rs2_reg <= AW'(rs1_reg) * AW'(rs1_reg);

            // stage 3: quadratic coefficients
            a3_reg <= vv2_reg[0] + vv2_reg[1] + vv2_reg[2];
            h3_reg <= HW'(pv2_reg[0]) + HW'(pv2_reg[1]) + HW'(pv2_reg[2]);
            c3_reg <= $signed(QW'(pp2_reg[0]) + QW'(pp2_reg[1]) + QW'(pp2_reg[2])
                              - QW'(rs2_reg));

            // stage 4: magnitudes
            hmag4_reg    <= h3_reg[HW-1] ? AW'(-h3_reg) : AW'(h3_reg);
            cmag4_reg    <= c3_reg[QW-1] ? AW'(-c3_reg) : AW'(c3_reg);
            cneg_reg[0]  <= c3_reg[QW-1];
            azero_reg[0] <= (a3_reg == '0);
            a4_reg       <= a3_reg;
            h4_reg       <= h3_reg;

            // stage 5: half-width partial products of h*h and a*|c|
            hh11_reg <= hmag4_reg[AW-1:HALF] * hmag4_reg[AW-1:HALF];
            hh10_reg <= hmag4_reg[AW-1:HALF] * hmag4_reg[HALF-1:0];
            hh00_reg <= hmag4_reg[HALF-1:0] * hmag4_reg[HALF-1:0];
            ac11_reg <= a4_reg[AW-1:HALF] * cmag4_reg[AW-1:HALF];
            ac10_reg <= a4_reg[AW-1:HALF] * cmag4_reg[HALF-1:0];
            ac01_reg <= a4_reg[HALF-1:0] * cmag4_reg[AW-1:HALF];
            ac00_reg <= a4_reg[HALF-1:0] * cmag4_reg[HALF-1:0];
            cneg_reg[1]  <= cneg_reg[0];
            azero_reg[1] <= azero_reg[0];
            a5_reg       <= a4_reg;
            h5_reg       <= h4_reg;

            // stage 6: recombine
            h2_reg <= (XW'(hh11_reg) << AW) + (XW'(hh10_reg) << (HALF + 1)) + XW'(hh00_reg);
            ac_reg <= (XW'(ac11_reg) << AW) + ((XW'(ac10_reg) + XW'(ac01_reg)) << HALF)
                      + XW'(ac00_reg);
            cneg_reg[2]  <= cneg_reg[1];
            azero_reg[2] <= azero_reg[1];
            a6_reg       <= a5_reg;
            h6_reg       <= h5_reg;
        end
    end

    // discriminant and classification
    assign diff = {1'b0, h2_reg} - {1'b0, ac_reg};
    assign sum  = h2_reg + ac_reg;

    always_comb
    begin
        job.go   = !azero_reg[2] && (cneg_reg[2] || !diff[XW]);
        job.disc = cneg_reg[2] ? sum : diff[XW-1:0];
        job.h    = h6_reg;
        job.a    = a6_reg;
        job.ca   = side_reg[FRONT_DEPTH-1].ca;
        job.va   = side_reg[FRONT_DEPTH-1].va;
        job.cb   = side_reg[FRONT_DEPTH-1].cb;
        job.vb   = side_reg[FRONT_DEPTH-1].vb;
        job.rb   = side_reg[FRONT_DEPTH-1].rb;
    end

endmodule

`default_nettype wire

/* hw/rtl/msc_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "moving_sphere_collision_macros.svh"

module msc_fifo import msc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  msc_job_t push_data,
    output logic     full,
    input  logic     pop,
    output msc_job_t pop_data,
    output logic     empty
);

    msc_job_t       mem_reg [FIFO_DEPTH];
    logic [FPW-1:0] wr_reg;
    logic [FPW-1:0] rd_reg;
    logic [FPW:0]   count_reg;

    assign full     = (count_reg == (FPW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    `MSC_ASSERT_IMP(a_no_overflow, push, !full || pop)
    `MSC_ASSERT_IMP(a_no_underflow, pop, !empty)

endmodule

`default_nettype wire

/* hw/rtl/msc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "moving_sphere_collision_macros.svh"

module msc_back import msc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     empty,
    output logic     pop,
    input  msc_job_t job,
    output logic     valid,
    input  logic     stall,
    output msc_out_t item
);

    typedef enum logic [3:0] {
        B_IDLE, B_ROOT, B_PICK, B_DIV, B_MUL, B_END, B_WDIF, B_WSQ, B_WSUM,
        B_LEN, B_CMUL, B_CLOAD, B_CDIV, B_CFIN, B_DONE
    } state_t;

    state_t               state_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [1:0]           comp_reg;
    msc_job_t             job_reg;
    logic [XW-1:0]        rad_reg;
    logic [SW:0]          rem_reg;
    logic [SW-1:0]        root_reg;
    logic [AW-1:0]        drem_reg;
    logic [TW-1:0]        dlow_reg;
    logic [TW-1:0]        dquo_reg;
    logic [AW-1:0]        dsor_reg;
    logic [TW-1:0]        t_reg;
    logic                 hit_reg;
    logic signed [PRW-1:0] proda_reg [3];
    logic signed [PRW-1:0] prodb_reg [3];
    logic signed [CW-1:0] ea_reg [3];
    logic signed [CW-1:0] eb_reg [3];
    logic signed [CW-1:0] oc_reg [3];
    logic signed [DW-1:0] w_reg [3];
    logic [AW-1:0]        sq_reg [3];
    logic [DW-1:0]        len_reg;
    logic [MW-1:0]        prodc_reg;
    logic                 valid_reg;
    msc_out_t             item_reg;

    logic [SW+2:0]        r_sh;
    logic [SW+2:0]        trial;
    logic                 sq_ge;
    logic [SW+2:0]        sq_diff;
    logic [AW:0]          d_sh;
    logic                 d_ge;
    logic [AW:0]          d_diff;
    logic signed [NW-1:0] nh;
    logic signed [NW-1:0] sx;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
    logic                 n_ok;
    logic [NW-2:0]        nval;
    logic                 ovf;
    logic signed [PRW-1:0] rnd_a [3];
    logic signed [PRW-1:0] rnd_b [3];
    logic signed [EW-1:0] move_a [3];
    logic signed [EW-1:0] move_b [3];
    logic signed [DW-1:0] w_sel;
    logic [DW-1:0]        wmag;
    logic [MW:0]          num;
    logic [DW-1:0]        len_fin;
    logic signed [EW-1:0] qs;
    logic                 out_free;
    msc_out_t             packed_res;

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign out_free = !valid_reg || !stall;
    assign valid    = valid_reg;
    assign item     = item_reg;

    // one bit of square root per cycle
    assign r_sh    = {rem_reg, rad_reg[XW-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign sq_ge   = (r_sh >= trial);
    assign sq_diff = r_sh - trial;
    assign len_fin = {root_reg[DW-2:0], sq_ge};

    // one quotient bit per cycle
    assign d_sh   = {drem_reg, dlow_reg[TW-1]};
    assign d_ge   = (d_sh >= {1'b0, dsor_reg});
    assign d_diff = d_sh - {1'b0, dsor_reg};

    // root choice: smaller if both non-negative, else the larger
    assign nh   = -(NW'(job_reg.h));
    assign sx   = $signed({2'b00, root_reg});
    assign n2   = nh - sx;
    assign n1   = nh + sx;
    assign n_ok = !n2[NW-1] || !n1[NW-1];
    assign nval = !n2[NW-1] ? n2[NW-2:0] : n1[NW-2:0];
    assign ovf  = (XW'(nval) >= (XW'(job_reg.a) << TFRAC));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd_a[i]  = proda_reg[i] + PRW'(RND);
            rnd_b[i]  = prodb_reg[i] + PRW'(RND);
            move_a[i] = EW'(coord(job_reg.ca, i)) + EW'(rnd_a[i] >>> TFRAC);
            move_b[i] = EW'(coord(job_reg.cb, i)) + EW'(rnd_b[i] >>> TFRAC);
        end
    end

    assign w_sel = w_reg[comp_reg];
    assign wmag  = w_sel[DW-1] ? DW'(-w_sel) : DW'(w_sel);
    assign num   = {prodc_reg, 1'b0} + (MW+1)'(len_reg);

    always_comb
    begin
        qs = EW'($signed({1'b0, dquo_reg[QB-1:0]}));
        if (w_sel[DW-1])
        begin
            qs = -qs;
        end
    end

    always_comb
    begin
        packed_res = '0;
        if (hit_reg)
        begin
            packed_res.hit           = 1'b1;
            packed_res.end_center_a  = {ea_reg[2], ea_reg[1], ea_reg[0]};
            packed_res.end_center_b  = {eb_reg[2], eb_reg[1], eb_reg[0]};
            packed_res.contact_point = {oc_reg[2], oc_reg[1], oc_reg[0]};
            packed_res.hit_time      = t_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            // in B_DONE the output register is reloaded instead
            if (valid_reg && !stall && state_reg != B_DONE)
            begin
                valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        job_reg  <= job;
                        rad_reg  <= job.disc;
                        rem_reg  <= '0;
                        root_reg <= '0;
                        cnt_reg  <= CNTW'(SW);
                        hit_reg  <= 1'b0;
                        state_reg <= job.go ? B_ROOT : B_DONE;
                    end
                end

                B_ROOT, B_LEN:
                begin
                    rad_reg  <= rad_reg << 2;
                    rem_reg  <= sq_ge ? sq_diff[SW:0] : r_sh[SW:0];
                    root_reg <= {root_reg[SW-2:0], sq_ge};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == CNTW'(1))
                    begin
                        if (state_reg == B_ROOT)
                        begin
                            state_reg <= B_PICK;
                        end
                        else
                        begin
                            len_reg  <= len_fin;
                            comp_reg <= '0;
                            if (len_fin == '0)
                            begin
                                oc_reg    <= eb_reg;
                                state_reg <= B_DONE;
                            end
                            else
                            begin
                                state_reg <= B_CMUL;
                            end
                        end
                    end
                end

                B_PICK:
                begin
                    if (!n_ok)
                    begin
                        state_reg <= B_DONE;
                    end
                    else
                    begin
                        hit_reg <= 1'b1;
                        if (ovf)
                        begin
                            t_reg     <= '1;
                            state_reg <= B_MUL;
                        end
                        else
                        begin
                            dsor_reg  <= job_reg.a;
                            drem_reg  <= AW'(nval >> TFRAC);
                            dlow_reg  <= {nval[TFRAC-1:0], (TW-TFRAC)'(0)};
                            dquo_reg  <= '0;
                            cnt_reg   <= CNTW'(TW);
                            state_reg <= B_DIV;
                        end
                    end
                end

                B_DIV, B_CDIV:
                begin
                    drem_reg <= d_ge ? d_diff[AW-1:0] : d_sh[AW-1:0];
                    dlow_reg <= dlow_reg << 1;
                    dquo_reg <= {dquo_reg[TW-2:0], d_ge};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == CNTW'(1))
                    begin
                        if (state_reg == B_DIV)
                        begin
                            t_reg     <= {dquo_reg[TW-2:0], d_ge};
                            state_reg <= B_MUL;
                        end
                        else
                        begin
                            state_reg <= B_CFIN;
                        end
                    end
                end

                B_MUL:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        proda_reg[i] <= coord(job_reg.va, i) * $signed({1'b0, t_reg});
                        prodb_reg[i] <= coord(job_reg.vb, i) * $signed({1'b0, t_reg});
                    end
                    state_reg <= B_END;
                end

                B_END:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        ea_reg[i] <= sat_coord(move_a[i]);
                        eb_reg[i] <= sat_coord(move_b[i]);
                    end
                    state_reg <= B_WDIF;
                end

                B_WDIF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        w_reg[i] <= DW'(ea_reg[i]) - DW'(eb_reg[i]);
                    end
                    state_reg <= B_WSQ;
                end

                B_WSQ:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sq_reg[i] <= w_reg[i] * w_reg[i];
                    end
                    state_reg <= B_WSUM;
                end

                B_WSUM:
                begin
                    rad_reg   <= XW'(sq_reg[0] + sq_reg[1] + sq_reg[2]);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= CNTW'(SW);
                    state_reg <= B_LEN;
                end

                B_CMUL:
                begin
                    prodc_reg <= MW'(wmag) * MW'(job_reg.rb);
                    state_reg <= B_CLOAD;
                end

                B_CLOAD:
                begin
                    dsor_reg  <= AW'({len_reg, 1'b0});
                    drem_reg  <= AW'(num >> QB);
                    dlow_reg  <= {num[QB-1:0], (TW-QB)'(0)};
                    dquo_reg  <= '0;
                    cnt_reg   <= CNTW'(QB);
                    state_reg <= B_CDIV;
                end

                B_CFIN:
                begin
                    oc_reg[comp_reg] <= sat_coord(EW'(eb_reg[comp_reg]) + qs);
                    if (comp_reg == 2'd2)
                    begin
                        state_reg <= B_DONE;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 1'b1;
                        state_reg <= B_CMUL;
                    end
                end

                B_DONE:
                begin
                    if (out_free)
                    begin
                        valid_reg <= 1'b1;
                        item_reg  <= packed_res;
                        state_reg <= B_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    `MSC_ASSERT_IMP(a_miss_clean, valid_reg && !item_reg.hit,
                    item_reg.hit_time == '0 && item_reg.contact_point == '0)
    `MSC_ASSERT_IMP(a_contact_in_radius, state_reg == B_CFIN,
                    dquo_reg[QB-1:0] <= QB'(job_reg.rb))

endmodule

`default_nettype wire

/* hw/rtl/moving_sphere_collision.sv */
`timescale 1ns / 1ps
`default_nettype none

// Continuous collision test for two moving spheres. Each req item carries
// two centres, radii and velocities (packed x,y,z signed Q12.8); each rsp
// item says whether the pair touches at a time >= 0 and, if so, both centres
// at that time, the contact point and the time in Q16.16, saturated at its
// maximum. A six-stage front end takes one item per clock unless the queue
// is full, forms the quadratic a t^2 + 2h t + c and its discriminant, and
// marks pairs with zero relative velocity or a negative discriminant as
// misses. A four-entry queue feeds the back end, which works one pair at a
// time: a hit runs a bit-serial square root of the discriminant, the time
// division, a root for the separation length and three divisions for the
// contact point; both roots share one shift-subtract root unit and all
// divisions share one divider. Sustained rate for hits is therefore set by
// these serial units; the front end and queue absorb bursts of up to ten
// items. No state survives an item and there is no configuration.

module moving_sphere_collision import msc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  msc_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output msc_out_t rsp
);

    logic     f_push;
    msc_job_t f_job;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    msc_job_t q_job;

    // front end: coefficients and discriminant, one item per clock unless the queue is full
    msc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (req_valid),
        .stall (req_stall),
        .item  (req),
        .push  (f_push),
        .job   (f_job),
        .full  (q_full)
    );

    // decoupling queue
    msc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data (f_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_job),
        .empty     (q_empty)
    );

    // back end: roots, time, end centres, contact point, output register
    msc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (q_empty),
        .pop   (q_pop),
        .job   (q_job),
        .valid (rsp_valid),
        .stall (rsp_stall),
        .item  (rsp)
    );

endmodule

`default_nettype wire

/* tb/sv/moving_sphere_collision_checker.sv */
`timescale 1ns / 1ps

module moving_sphere_collision_checker import msc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_stall,
    input  msc_in_t  req,
    input  logic     rsp_valid,
    input  logic     rsp_stall,
    input  msc_out_t rsp,
    output int       errors,
    output int       pending,
    output int       hits_seen
);

    msc_out_t collisions_due[$];

    function automatic logic signed [63:0] comp(input logic [VW-1:0] v, input int i);
        logic signed [CW-1:0] c;
        c = v[i*CW +: CW];
        return 64'(c);
    endfunction

    function automatic logic signed [63:0] clamp(input logic signed [63:0] x);
        if (x > 64'sd524287)
        begin
            return 64'sd524287;
        end
        if (x < -64'sd524288)
        begin
            return -64'sd524288;
        end
        return x;
    endfunction

    function automatic logic [63:0] root(input logic [127:0] d);
        logic [63:0]  y;
        logic [63:0]  cand;
        y = 0;
        for (int b = 45; b >= 0; b--)
        begin
            cand = y | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= d)
            begin
                y = cand;
            end
        end
        return y;
    endfunction

    // add half then floor, per Q16.16 time
    function automatic logic signed [63:0] rshift(input logic signed [63:0] x);
        logic signed [63:0] b;
        b = x + 64'sd32768;
        return b >>> 16;
    endfunction

    function automatic msc_out_t collide(input msc_in_t q);
        msc_out_t r;
        logic signed [63:0] pa[3], va[3], pb[3], vb[3], p[3], v[3], ea[3], eb[3], w[3];
        logic signed [63:0] h, c, n, qq;
        logic signed [127:0] d;
        logic [63:0] a, s, t, ww, len, rs, num;
        r = '0;
        a = 0;
        h = 0;
        c = 0;
        rs = 64'(q.radius_a) + 64'(q.radius_b);
        for (int i = 0; i < 3; i++)
        begin
            pa[i] = comp(q.center_a, i);
            va[i] = comp(q.velocity_a, i);
            pb[i] = comp(q.center_b, i);
            vb[i] = comp(q.velocity_b, i);
            p[i] = pb[i] - pa[i];
            v[i] = vb[i] - va[i];
            a += v[i] * v[i];
            h += p[i] * v[i];
            c += p[i] * p[i];
        end
        if (a == 0)
        begin
            return r;
        end
        c = c - $signed(rs * rs);
        d = 128'(h) * 128'(h) - 128'($signed({1'b0, a})) * 128'(c);
        if (d < 0)
        begin
            return r;
        end
        s = root(d);
        if (-h - $signed(s) >= 0)
        begin
            n = -h - $signed(s);
        end
        else if (-h + $signed(s) >= 0)
        begin
            n = -h + $signed(s);
        end
        else
        begin
            return r;
        end
        t = 64'((128'(n) << 16) / 128'(a));
        if (t > 64'hFFFF_FFFF)
        begin
            t = 64'hFFFF_FFFF;
        end
        ww = 0;
        for (int i = 0; i < 3; i++)
        begin
            ea[i] = clamp(pa[i] + rshift(va[i] * $signed(t)));
            eb[i] = clamp(pb[i] + rshift(vb[i] * $signed(t)));
            w[i] = ea[i] - eb[i];
            ww += w[i] * w[i];
        end
        len = root(128'(ww));
        r.hit = 1'b1;
        r.hit_time = t[31:0];
        for (int i = 0; i < 3; i++)
        begin
            qq = 0;
            if (len != 0)
            begin
                num = 64'(w[i] < 0 ? -w[i] : w[i]) * 64'(q.radius_b) * 2 + len;
                qq = $signed(num / (2 * len));
                if (w[i] < 0)
                begin
                    qq = -qq;
                end
            end
            qq = clamp(eb[i] + qq);
            r.end_center_a[i*CW +: CW] = ea[i][CW-1:0];
            r.end_center_b[i*CW +: CW] = eb[i][CW-1:0];
            r.contact_point[i*CW +: CW] = qq[CW-1:0];
        end
        return r;
    endfunction

    assign pending = collisions_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        msc_out_t e;
        if (!rst_n)
        begin
            errors = 0;
            hits_seen = 0;
            collisions_due.delete();
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                collisions_due.push_back(collide(req));
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (collisions_due.size() == 0)
                begin
                    $error("unexpected result item %p", rsp);
                    errors++;
                end
                else
                begin
                    e = collisions_due.pop_front();
                    hits_seen += int'(rsp.hit);
                    if (rsp.hit !== e.hit)
                    begin
                        $error("hit: expected %0h got %0h", e.hit, rsp.hit);
                        errors++;
                    end
                    if (rsp.end_center_a !== e.end_center_a)
                    begin
                        $error("end_center_a: expected %0h got %0h",
                               e.end_center_a, rsp.end_center_a);
                        errors++;
                    end
                    if (rsp.end_center_b !== e.end_center_b)
                    begin
                        $error("end_center_b: expected %0h got %0h",
                               e.end_center_b, rsp.end_center_b);
                        errors++;
                    end
                    if (rsp.contact_point !== e.contact_point)
                    begin
                        $error("contact_point: expected %0h got %0h",
                               e.contact_point, rsp.contact_point);
                        errors++;
                    end
                    if (rsp.hit_time !== e.hit_time)
                    begin
                        $error("hit_time: expected %0h got %0h", e.hit_time, rsp.hit_time);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/moving_sphere_collision_test.sv */
`timescale 1ns / 1ps

// Stimulus and verdict. Prediction and comparison live in the checker.
module moving_sphere_collision_test import msc_pkg::*;;

    localparam int WATCHDOG_LIMIT = 20000;   // idle limit; receiver stalls stretch a hit

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    msc_in_t  req;
    logic     rsp_valid;
    logic     rsp_stall;
    msc_out_t rsp;
    int       errors;
    int       pending;
    int       hits_seen;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       idle_cycles;
    int       items_sent;

    moving_sphere_collision uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    moving_sphere_collision_checker chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .errors(errors), .pending(pending), .hits_seen(hits_seen)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge clk)
    begin
        rsp_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT)
            begin
                $display("watchdog expired");
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [VW-1:0] vec(input int x, input int y, input int z);
        return {20'(z), 20'(y), 20'(x)};
    endfunction

    function automatic logic [VW-1:0] rand_vec(input int span);
        int x, y, z;
        x = $urandom_range(2 * span) - span;
        y = $urandom_range(2 * span) - span;
        z = $urandom_range(2 * span) - span;
        return vec(x, y, z);
    endfunction

    // valid stays high from one item to the next unless the sender idles
    task automatic send(input msc_in_t item);
        while ((send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct))
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic int comp_of(input logic [VW-1:0] v, input int i);
        logic signed [CW-1:0] c;
        c = v[i*CW +: CW];
        return int'(c);
    endfunction

    // pair set on a likely collision course, with random content otherwise
    function automatic msc_in_t approaching();
        msc_in_t q;
        int span;
        span = ($urandom_range(9) == 0) ? 262143 : 16384;
        q.center_a   = rand_vec(span);
        q.center_b   = rand_vec(span);
        q.radius_a   = $urandom_range(9) == 0 ? 20'($urandom) : 20'($urandom_range(4096));
        q.radius_b   = $urandom_range(9) == 0 ? 20'($urandom) : 20'($urandom_range(4096));
        // velocity of a heads toward b, b drifts
        q.velocity_a = vec((comp_of(q.center_b, 0) - comp_of(q.center_a, 0)) / 4,
                           (comp_of(q.center_b, 1) - comp_of(q.center_a, 1)) / 4,
                           (comp_of(q.center_b, 2) - comp_of(q.center_a, 2)) / 4);
        q.velocity_b = rand_vec(256);
        return q;
    endfunction

    task automatic random_phase(input int count);
        msc_in_t      q;
        logic [319:0] raw;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < 70)
            begin
                q = approaching();
            end
            else
            begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom};
                q = raw[$bits(msc_in_t)-1:0];
            end
            send(q);
        end
    endtask

    initial
    begin
        msc_in_t q;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent = 0;
        idle_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero relative velocity (all zero, then equal velocities)
        send('0);
        q = '0;
        q.velocity_a = vec(256, 0, 0);
        q.velocity_b = vec(256, 0, 0);
        send(q);
        // head-on approach, both roots positive
        q = '0;
        q.center_b = vec(2560, 0, 0);
        q.radius_a = 20'd256;
        q.radius_b = 20'd256;
        q.velocity_a = vec(256, 0, 0);
        send(q);
        // moving apart: both roots negative
        q.velocity_a = vec(-256, 0, 0);
        send(q);
        // miss sideways: negative discriminant
        q.center_b = vec(2560, 5000, 0);
        q.velocity_a = vec(256, 0, 0);
        send(q);
        // already overlapping: one root negative, larger taken
        q.center_b = vec(100, 0, 0);
        send(q);
        // identical centres and zero radii: contact point with coincident end centres
        q = '0;
        q.velocity_b = vec(1, 1, 1);
        send(q);
        // tiny closing speed from far: time saturates
        q = '0;
        q.center_a = vec(-524288, 0, 0);
        q.center_b = vec(524287, 0, 0);
        q.velocity_a = vec(1, 0, 0);
        send(q);
        // field extremes
        q = '1;
        send(q);
        q.center_a = vec(-524288, 524287, -524288);
        q.center_b = vec(524287, -524288, 524287);
        q.velocity_a = vec(524287, -524288, 0);
        q.velocity_b = vec(-524288, 524287, 0);
        q.radius_a = 20'hFFFFF;
        q.radius_b = '0;
        send(q);
        q.radius_a = '0;
        q.radius_b = 20'hFFFFF;
        send(q);
        // hold off until every result is back
        drain();

        send_idle_pct = 29;
        recv_idle_pct = 62;
        random_phase(630);
        send_idle_pct = 62;
        recv_idle_pct = 29;
        random_phase(630);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(630);

        drain();
        repeat (300) @(negedge clk);
        $display("%0d pairs sent, %0d collisions returned, with and without back-pressure",
                 items_sent, hits_seen);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
